FILE: hdl/ocle_pkg.sv
// Shared types for the ordered byte list engine.
package ocle_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_FIND   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ocle_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan;
		logic last;
	} ocle_stat_t;

endpackage

FILE: hdl/ocle_ctrl.sv
// Command sequencer for the ordered byte list engine.
module ocle_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  ocle_pkg::ocle_stat_t  st,
	output ocle_pkg::ocle_cmd_t   cmd
);
	import ocle_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!st.scan)
						state_q <= S_FINISH;
					else if (st.last)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.step   = (state_q == S_SCAN) && st.scan;
	assign cmd.finish = (state_q == S_FINISH);

endmodule

FILE: hdl/ocle_dp.sv
// List storage, shift/scan pipeline and result registers.
module ocle_dp #(
	parameter int DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ocle_pkg::ocle_cmd_t   cmd,
	output ocle_pkg::ocle_stat_t  st,
	input  logic [1:0]            mode,
	input  logic [7:0]            value,
	input  logic [6:0]            position,
	input  logic                  at_end,
	output logic                  ok,
	output logic [7:0]            removed_value,
	output logic                  found,
	output logic [5:0]            found_position,
	output logic [6:0]            length
);
	import ocle_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (CW > 7) ? CW : 7;

	logic [7:0]    mem [DEPTH];

	mode_t         mode_q;
	logic [7:0]    value_q;
	logic [AW-1:0] ptr_q, stop_q, pos_q;
	logic          up_q, ok_q, scan_q;
	logic [CW-1:0] count_q;
	logic [7:0]    removed_q;
	logic          found_q;
	logic [AW-1:0] fpos_q;

	logic          vld_s1;
	logic [AW-1:0] ptr_s1;
	logic [7:0]    rdata_s1;

	logic [WW-1:0] cnt_w, pos_w, ins_pos, rem_pos;
	logic          l_ok, l_scan, l_up;
	logic [AW-1:0] l_start, l_stop, l_pos;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;

	logic [CW-1:0] new_count;
	logic [WW-1:0] nc_w, fpos_w;

	// command decode at accept
	always_comb begin
		cnt_w   = WW'(count_q);
		pos_w   = WW'(position);
		ins_pos = at_end ? cnt_w : pos_w;
		rem_pos = at_end ? (cnt_w - WW'(1)) : pos_w;
		l_ok    = 1'b1;
		l_scan  = 1'b0;
		l_up    = 1'b1;
		l_start = '0;
		l_stop  = '0;
		l_pos   = '0;
		case (mode_t'(mode))
			MODE_INSERT: begin
				l_ok    = (cnt_w < WW'(DEPTH)) && (ins_pos <= cnt_w);
				l_scan  = l_ok && (ins_pos < cnt_w);
				l_up    = 1'b0;
				l_start = AW'(cnt_w - WW'(1));
				l_stop  = AW'(ins_pos);
				l_pos   = AW'(ins_pos);
			end
			MODE_REMOVE: begin
				l_ok    = (cnt_w != '0) && (rem_pos < cnt_w);
				l_scan  = l_ok;
				l_start = AW'(rem_pos);
				l_stop  = AW'(cnt_w - WW'(1));
				l_pos   = AW'(rem_pos);
			end
			MODE_FIND: begin
				l_scan  = (cnt_w != '0);
				l_stop  = AW'(cnt_w - WW'(1));
			end
			default: begin
				l_ok    = 1'b1;
			end
		endcase
	end

	// single write port: shift moves, then the inserted byte
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_s1;
		wr_data = rdata_s1;
		if (cmd.finish && ok_q && (mode_q == MODE_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = value_q;
		end else if (vld_s1 && (mode_q == MODE_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = ptr_s1 + AW'(1);
		end else if (vld_s1 && (mode_q == MODE_REMOVE) && (ptr_s1 != pos_q)) begin
			wr_en   = 1'b1;
			wr_addr = ptr_s1 - AW'(1);
		end
	end

	always_comb begin
		case (mode_q)
			MODE_INSERT: new_count = ok_q ? (count_q + CW'(1)) : count_q;
			MODE_REMOVE: new_count = ok_q ? (count_q - CW'(1)) : count_q;
			MODE_CLEAR:  new_count = '0;
			default:     new_count = count_q;
		endcase
		nc_w   = WW'(new_count);
		fpos_w = WW'(fpos_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.step)
			rdata_s1 <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q  <= 1'b0;
			ok_q    <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			if (cmd.load) begin
				scan_q <= l_scan;
				ok_q   <= l_ok;
			end
			if (cmd.finish)
				count_q <= new_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= mode_t'(mode);
			value_q   <= value;
			ptr_q     <= l_start;
			stop_q    <= l_stop;
			pos_q     <= l_pos;
			up_q      <= l_up;
			removed_q <= '0;
			found_q   <= 1'b0;
			fpos_q    <= '0;
		end else if (cmd.step) begin
			ptr_q <= up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
		end
		if (cmd.step)
			ptr_s1 <= ptr_q;
		if (vld_s1) begin
			case (mode_q)
				MODE_REMOVE: begin
					if (ptr_s1 == pos_q)
						removed_q <= rdata_s1;
				end
				MODE_FIND: begin
					if (!found_q && (rdata_s1 == value_q)) begin
						found_q <= 1'b1;
						fpos_q  <= ptr_s1;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.finish) begin
			ok             <= ok_q;
			removed_value  <= removed_q;
			found          <= found_q;
			found_position <= fpos_w[5:0];
			length         <= nc_w[6:0];
		end
	end

	assign st.scan = scan_q;
	assign st.last = (ptr_q == stop_q);

endmodule

FILE: hdl/ordered_char_list_engine_core.sv
// Top level of the ordered byte list engine.
//
//  channel   handshake            payload
//  command   start & !busy        mode, value, position, at_end
//  result    done (one cycle)     ok, removed_value, found, found_position, length
//
// A command walks n entries of the list memory between accept and done:
// they are shifted for insert/remove and compared for find.
// n is at most DEPTH; clear and failed commands walk no entries.
// busy drops in the cycle done is high, so the next command may be accepted then.
// Reset empties the list; no clearing pass, stored bytes are only read below length.
// Results are not held off by the receiver.
module ordered_char_list_engine_core #(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [7:0] value,
	input  logic [6:0] position,
	input  logic       at_end,
	output logic       done,
	output logic       ok,
	output logic [7:0] removed_value,
	output logic       found,
	output logic [5:0] found_position,
	output logic [6:0] length
);
	import ocle_pkg::*;

	ocle_cmd_t  cmd;
	ocle_stat_t st;

	ocle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.st     (st),
		.cmd    (cmd)
	);

	ocle_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.mode           (mode),
		.value          (value),
		.position       (position),
		.at_end         (at_end),
		.ok             (ok),
		.removed_value  (removed_value),
		.found          (found),
		.found_position (found_position),
		.length         (length)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe outside command end");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> ((removed_value == 8'd0) && !found && (found_position == 6'd0)))
		else $error("failed command reports data");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (ok && (removed_value == 8'd0)))
		else $error("find result inconsistent");
`endif

endmodule
